/* rtl/clrle_pkg.sv */
// Package for the code-length run-length encoder: token codes, run limits,
// token and token-group types and the run flush function. No dependencies.
package clrle_pkg;

  localparam int CodeLenW  = 4;
  localparam int SymW      = 5;
  localparam int CntW      = 8;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 16;
  localparam int SlotCnt   = 3;
  localparam int SlotIdxW  = 2;

  localparam logic [SymW-1:0] SymRepeat    = 5'd16;
  localparam logic [SymW-1:0] SymZeroShort = 5'd17;
  localparam logic [SymW-1:0] SymZeroLong  = 5'd18;

  localparam logic [CntW-1:0] ZeroLongMax  = 8'd138;
  localparam logic [CntW-1:0] ZeroLongMin  = 8'd11;
  localparam logic [CntW-1:0] ZeroShortMin = 8'd3;
  localparam logic [CntW-1:0] RepeatMax    = 8'd6;
  localparam logic [CntW-1:0] RepeatMin    = 8'd3;

  // One output token with its framing flags.
  typedef struct packed {
    logic [SymW-1:0] sym;
    logic [CntW-1:0] cnt;
    logic            last;
    logic            eot;
  } token_t;

  // A group of n identical tokens (n = 0..2).
  typedef struct packed {
    logic [SlotIdxW-1:0] n;
    logic [SymW-1:0]     sym;
    logic [CntW-1:0]     cnt;
  } group_t;

  // Tokens that close an open run holding the given pending count.
  function automatic group_t flush_group(input logic active,
                                         input logic [CodeLenW-1:0] value,
                                         input logic [CntW-1:0] count);
    group_t g;
    g.n   = '0;
    g.sym = '0;
    g.cnt = 8'd1;
    if (active) begin
      if (value == '0) begin
        if (count >= ZeroLongMin) begin
          g.n = 2'd1; g.sym = SymZeroLong; g.cnt = count;
        end else if (count >= ZeroShortMin) begin
          g.n = 2'd1; g.sym = SymZeroShort; g.cnt = count;
        end else begin
          g.n = count[SlotIdxW-1:0];
          g.sym = '0;
        end
      end else begin
        if (count >= RepeatMin) begin
          g.n = 2'd1; g.sym = SymRepeat; g.cnt = count;
        end else begin
          g.n = count[SlotIdxW-1:0];
          g.sym = {1'b0, value};
        end
      end
    end
    return g;
  endfunction

endpackage

/* rtl/code_length_run_length_encoder_unit.sv */
// Top level of the code-length run-length encoder.
// Depends on clrle_pkg for token codes, run limits and the flush function.
//
// Takes one Huffman code length per item and emits DEFLATE code-length tokens
// (0..15 literal, 16 repeat previous, 17/18 zero runs) greedily: a nonzero
// literal goes out when its run starts, a full 16(6) or 18(138) as soon as it
// fills, and the rest of a run when the value changes or the list ends
// (in_tlast). An item causes zero to three tokens; out_tuser marks the last
// token of each item and out_tlast the last token of the list. An item is
// taken into an input register, then in one step turned into its tokens, which
// are loaded into a three-slot token buffer that drains through the single
// output port at one token per cycle while out_tready is high. Throughput is
// one item per cycle while each item yields at most one token and the output
// does not stall; more tokens per item hold the buffer, so the output port sets
// the rate. An empty input register takes a new item while tokens still wait.
module code_length_run_length_encoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [clrle_pkg::InDataW-1:0]   in_tdata,   // [3:0] code_length, [7:4] zero
  input  logic                            in_tlast,   // end_of_list
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [clrle_pkg::OutDataW-1:0]  out_tdata,  // [4:0] token_symbol,
                                                      // [12:5] repeat_count, [15:13] zero
  output logic                            out_tlast,  // end_of_tokens
  output logic                            out_tuser   // last_of_item
);
  import clrle_pkg::*;

  // Input register
  logic                iv_r;
  logic [CodeLenW-1:0] icode_r;
  logic                ieol_r;

  // Run state
  logic                run_active_r, run_active_nxt;
  logic [CodeLenW-1:0] run_value_r, run_value_nxt;
  logic [CntW-1:0]     pending_r, pending_nxt;

  // Token buffer, slot 0 is at the output
  token_t              tok_r [SlotCnt];
  token_t              tok_nxt [SlotCnt];
  logic [SlotIdxW-1:0] rem_r;
  logic [SlotIdxW-1:0] n_nxt;

  logic pop, load;

  group_t grp_a, grp_b, grp_c;
  logic   match;
  logic [CntW-1:0] inc;
  logic [CntW-1:0] pend_after;

  assign pop  = out_tvalid & out_tready;
  assign load = iv_r & ((rem_r == '0) | ((rem_r == 2'd1) & pop));
  assign in_tready = ~iv_r | load;

  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = {3'b000, tok_r[0].cnt, tok_r[0].sym};
  assign out_tlast  = tok_r[0].eot;
  assign out_tuser  = tok_r[0].last;

  // Token generation for the item in the input register. Three groups in order:
  // A closes the previous run, B is a literal or a full block, C is the final
  // flush at the end of the list.
  always_comb begin
    match = run_active_r & (icode_r == run_value_r);
    inc   = pending_r + 8'd1;
    grp_a = '{n: '0, sym: '0, cnt: 8'd1};
    grp_b = '{n: '0, sym: '0, cnt: 8'd1};
    pend_after = '0;
    if (match) begin
      if (icode_r == '0) begin
        if (inc >= ZeroLongMax) begin
          grp_b = '{n: 2'd1, sym: SymZeroLong, cnt: ZeroLongMax};
        end else begin
          pend_after = inc;
        end
      end else begin
        if (inc >= RepeatMax) begin
          grp_b = '{n: 2'd1, sym: SymRepeat, cnt: RepeatMax};
        end else begin
          pend_after = inc;
        end
      end
    end else begin
      grp_a = flush_group(run_active_r, run_value_r, pending_r);
      if (icode_r == '0) begin
        pend_after = 8'd1;
      end else begin
        grp_b = '{n: 2'd1, sym: {1'b0, icode_r}, cnt: 8'd1};
      end
    end
    grp_c = flush_group(ieol_r, icode_r, pend_after);

    n_nxt = grp_a.n + grp_b.n + grp_c.n;

    for (int k = 0; k < SlotCnt; k++) begin
      if (SlotIdxW'(k) < grp_a.n) begin
        tok_nxt[k].sym = grp_a.sym;
        tok_nxt[k].cnt = grp_a.cnt;
      end else if (SlotIdxW'(k) < (grp_a.n + grp_b.n)) begin
        tok_nxt[k].sym = grp_b.sym;
        tok_nxt[k].cnt = grp_b.cnt;
      end else begin
        tok_nxt[k].sym = grp_c.sym;
        tok_nxt[k].cnt = grp_c.cnt;
      end
      tok_nxt[k].last = (SlotIdxW'(k) == (n_nxt - 2'd1));
      tok_nxt[k].eot  = tok_nxt[k].last & ieol_r;
    end

    // The end of the list closes the run
    run_value_nxt  = icode_r;
    run_active_nxt = ~ieol_r;
    pending_nxt    = ieol_r ? '0 : pend_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r         <= 1'b0;
      rem_r        <= '0;
      run_active_r <= 1'b0;
      run_value_r  <= '0;
      pending_r    <= '0;
    end else begin
      // Hold or refill the input register
      if (in_tready) begin
        iv_r <= in_tvalid;
      end
      if (load) begin
        rem_r        <= n_nxt;
        run_active_r <= run_active_nxt;
        run_value_r  <= run_value_nxt;
        pending_r    <= pending_nxt;
      end else if (pop) begin
        rem_r <= rem_r - 2'd1;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready) begin
      icode_r <= in_tdata[CodeLenW-1:0];
      ieol_r  <= in_tlast;
    end
    if (load) begin
      for (int k = 0; k < SlotCnt; k++) begin
        tok_r[k] <= tok_nxt[k];
      end
    end else if (pop) begin
      // Advance the buffer by one token
      for (int k = 0; k < SlotCnt - 1; k++) begin
        tok_r[k] <= tok_r[k+1];
      end
    end
  end

endmodule
